### sv/nec_ir_pkg.sv
package nec_ir_pkg;

   localparam int unsigned TICK_WIDTH   = 15;
   localparam int unsigned MARGIN_WIDTH = 9;
   localparam int unsigned INDEX_WIDTH  = 6;
   localparam int unsigned CODE_WIDTH   = 16;
   localparam int unsigned CSR_WIDTH    = 15;

   localparam logic [INDEX_WIDTH-1:0] INDEX_MAX      = 6'd63;
   localparam logic [INDEX_WIDTH-1:0] LAST_BIT_INDEX = 6'd32;
   localparam logic [INDEX_WIDTH-1:0] FRAME_SYMBOLS  = 6'd34;
   localparam logic [INDEX_WIDTH-1:0] REPEAT_SYMBOLS = 6'd2;

   localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET       = 9'd200;
   localparam logic [TICK_WIDTH-1:0]   LEADER_MARK_RESET  = 15'd9000;
   localparam logic [TICK_WIDTH-1:0]   LEADER_SPACE_RESET = 15'd4500;
   localparam logic [TICK_WIDTH-1:0]   REPEAT_SPACE_RESET = 15'd2250;
   localparam logic [TICK_WIDTH-1:0]   BIT_MARK_RESET     = 15'd560;
   localparam logic [TICK_WIDTH-1:0]   ZERO_SPACE_RESET   = 15'd560;
   localparam logic [TICK_WIDTH-1:0]   ONE_SPACE_RESET    = 15'd1690;

   typedef enum logic [2:0] {
      CSR_DECODE_MARGIN      = 3'd0,
      CSR_LEADER_MARK_TICKS  = 3'd1,
      CSR_LEADER_SPACE_TICKS = 3'd2,
      CSR_REPEAT_SPACE_TICKS = 3'd3,
      CSR_BIT_MARK_TICKS     = 3'd4,
      CSR_ZERO_SPACE_TICKS   = 3'd5,
      CSR_ONE_SPACE_TICKS    = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      FRAME_NEW_CODE       = 2'd0,
      FRAME_REPEAT         = 2'd1,
      FRAME_TIMING_ERROR   = 2'd2,
      FRAME_UNKNOWN_LENGTH = 2'd3
   } frame_status_type;

   typedef struct packed {
      logic [TICK_WIDTH-1:0] mark_ticks;
      logic [TICK_WIDTH-1:0] space_ticks;
      logic                  frame_end;
   } req_word_type;

   typedef struct packed {
      frame_status_type      frame_status;
      logic [CODE_WIDTH-1:0] code_address;
      logic [CODE_WIDTH-1:0] code_command;
   } rsp_word_type;

   // Strict window n - m < d < n + m. The lower bound is tested as d + m > n,
   // so a margin larger than the nominal value opens the window down to zero.
   function automatic logic in_window(input logic [TICK_WIDTH-1:0]   d,
                                      input logic [TICK_WIDTH-1:0]   n,
                                      input logic [MARGIN_WIDTH-1:0] m);
      logic [TICK_WIDTH:0] upper;
      logic [TICK_WIDTH:0] lifted;
      upper  = {1'b0, n} + {{(TICK_WIDTH+1-MARGIN_WIDTH){1'b0}}, m};
      lifted = {1'b0, d} + {{(TICK_WIDTH+1-MARGIN_WIDTH){1'b0}}, m};
      return ({1'b0, d} < upper) && (lifted > {1'b0, n});
   endfunction

endpackage

### sv/nec_ir_frame_decoder_core.sv
// Decoder for NEC infrared remote frames, one pulse symbol per word.
// Request channel (req_*): each word carries the mark and space durations of
// one symbol and a flag on the last symbol of a frame. Response channel
// (rsp_*): one word per frame, sent for the symbol that carries frame_end,
// with the frame status and the decoded or saved address and command.
// A word accepted at a clock edge is held in the input register and decoded
// there; a frame-ending symbol loads the response register once no stalled
// response is pending. The block takes one word per cycle while req_stall
// is low; symbols that do not end a frame never wait on the response side.
// The window compares of one symbol are the whole path between the input
// register and the response register. Reset empties both registers, clears
// the frame state and saved code, and loads the default timing registers.
// When the receiver stalls, the response holds, and the block keeps taking
// words until a frame-ending symbol reaches the input register; req_stall
// then rises until the pending response is taken.
// The csr_* port writes a timing register at any edge with csr_write_enable
// high; the user must use it only while idle, as the block itself does not
// enforce this.
module nec_ir_frame_decoder_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  nec_ir_pkg::req_word_type             req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output nec_ir_pkg::rsp_word_type             rsp_data,
   input  logic                                 csr_write_enable,
   input  nec_ir_pkg::csr_index_type            csr_index,
   input  logic [nec_ir_pkg::CSR_WIDTH-1:0]     csr_wdata
);

   logic [nec_ir_pkg::MARGIN_WIDTH-1:0] margin_ff;
   logic [nec_ir_pkg::TICK_WIDTH-1:0]   leader_mark_ff;
   logic [nec_ir_pkg::TICK_WIDTH-1:0]   leader_space_ff;
   logic [nec_ir_pkg::TICK_WIDTH-1:0]   repeat_space_ff;
   logic [nec_ir_pkg::TICK_WIDTH-1:0]   bit_mark_ff;
   logic [nec_ir_pkg::TICK_WIDTH-1:0]   zero_space_ff;
   logic [nec_ir_pkg::TICK_WIDTH-1:0]   one_space_ff;

   logic                     hold_valid_ff, hold_valid_in;
   nec_ir_pkg::req_word_type hold_word_ff;

   logic [nec_ir_pkg::INDEX_WIDTH-1:0] symbol_index_ff, symbol_index_in;
   logic                               leader_good_ff, leader_good_in;
   logic                               repeat_good_ff, repeat_good_in;
   logic                               bits_good_ff, bits_good_in;
   logic [2*nec_ir_pkg::CODE_WIDTH-1:0] payload_shift_ff, payload_shift_in;
   logic [nec_ir_pkg::CODE_WIDTH-1:0]  saved_address_ff, saved_address_in;
   logic [nec_ir_pkg::CODE_WIDTH-1:0]  saved_command_ff, saved_command_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   nec_ir_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic req_take;
   logic advance;
   logic out_free;
   logic mark_leader_ok;
   logic mark_bit_ok;
   logic one_ok;
   logic zero_ok;
   logic [nec_ir_pkg::INDEX_WIDTH-1:0] count;
   logic [4:0] bit_pos;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = hold_valid_ff && (!hold_word_ff.frame_end || out_free);
   assign req_stall = hold_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   assign mark_leader_ok = nec_ir_pkg::in_window(hold_word_ff.mark_ticks, leader_mark_ff,
                                                 margin_ff);
   assign mark_bit_ok    = nec_ir_pkg::in_window(hold_word_ff.mark_ticks, bit_mark_ff,
                                                 margin_ff);
   assign one_ok         = nec_ir_pkg::in_window(hold_word_ff.space_ticks, one_space_ff,
                                                 margin_ff);
   assign zero_ok        = nec_ir_pkg::in_window(hold_word_ff.space_ticks, zero_space_ff,
                                                 margin_ff);
   assign bit_pos        = 5'(symbol_index_ff - 6'd1);
   assign count          = (symbol_index_ff < nec_ir_pkg::INDEX_MAX) ?
                           symbol_index_ff + 6'd1 : nec_ir_pkg::INDEX_MAX;

   assign hold_valid_in = req_take || (hold_valid_ff && !advance);

   always_comb begin
      logic leader_upd, repeat_upd, bits_upd;
      logic [2*nec_ir_pkg::CODE_WIDTH-1:0] shift_upd;

      leader_upd = leader_good_ff;
      repeat_upd = repeat_good_ff;
      bits_upd   = bits_good_ff;
      shift_upd  = payload_shift_ff;

      symbol_index_in  = symbol_index_ff;
      leader_good_in   = leader_good_ff;
      repeat_good_in   = repeat_good_ff;
      bits_good_in     = bits_good_ff;
      payload_shift_in = payload_shift_ff;
      saved_address_in = saved_address_ff;
      saved_command_in = saved_command_ff;
      rsp_word_in      = rsp_word_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;

      if (symbol_index_ff == '0) begin
         leader_upd = mark_leader_ok &&
                      nec_ir_pkg::in_window(hold_word_ff.space_ticks, leader_space_ff,
                                            margin_ff);
         repeat_upd = mark_leader_ok &&
                      nec_ir_pkg::in_window(hold_word_ff.space_ticks, repeat_space_ff,
                                            margin_ff);
      end else if (symbol_index_ff <= nec_ir_pkg::LAST_BIT_INDEX) begin
         // A bad symbol shifts in a zero and spoils the whole frame.
         shift_upd[bit_pos] = mark_bit_ok && one_ok;
         if (!(mark_bit_ok && (one_ok || zero_ok))) begin
            bits_upd = 1'b0;
         end
      end

      if (advance) begin
         if (!hold_word_ff.frame_end) begin
            symbol_index_in  = count;
            leader_good_in   = leader_upd;
            repeat_good_in   = repeat_upd;
            bits_good_in     = bits_upd;
            payload_shift_in = shift_upd;
         end else begin
            symbol_index_in  = '0;
            leader_good_in   = 1'b0;
            repeat_good_in   = 1'b0;
            bits_good_in     = 1'b1;
            payload_shift_in = '0;
            rsp_valid_in     = 1'b1;
            rsp_word_in.code_address = saved_address_ff;
            rsp_word_in.code_command = saved_command_ff;
            if (count == nec_ir_pkg::FRAME_SYMBOLS) begin
               if (leader_upd && bits_upd) begin
                  saved_address_in = shift_upd[nec_ir_pkg::CODE_WIDTH-1:0];
                  saved_command_in = shift_upd[2*nec_ir_pkg::CODE_WIDTH-1:
                                               nec_ir_pkg::CODE_WIDTH];
                  rsp_word_in.code_address = shift_upd[nec_ir_pkg::CODE_WIDTH-1:0];
                  rsp_word_in.code_command = shift_upd[2*nec_ir_pkg::CODE_WIDTH-1:
                                                       nec_ir_pkg::CODE_WIDTH];
                  rsp_word_in.frame_status = nec_ir_pkg::FRAME_NEW_CODE;
               end else begin
                  rsp_word_in.frame_status = nec_ir_pkg::FRAME_TIMING_ERROR;
               end
            end else if (count == nec_ir_pkg::REPEAT_SYMBOLS) begin
               rsp_word_in.frame_status = repeat_upd ? nec_ir_pkg::FRAME_REPEAT :
                                                       nec_ir_pkg::FRAME_TIMING_ERROR;
            end else begin
               rsp_word_in.frame_status = nec_ir_pkg::FRAME_UNKNOWN_LENGTH;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff       <= nec_ir_pkg::MARGIN_RESET;
         leader_mark_ff  <= nec_ir_pkg::LEADER_MARK_RESET;
         leader_space_ff <= nec_ir_pkg::LEADER_SPACE_RESET;
         repeat_space_ff <= nec_ir_pkg::REPEAT_SPACE_RESET;
         bit_mark_ff     <= nec_ir_pkg::BIT_MARK_RESET;
         zero_space_ff   <= nec_ir_pkg::ZERO_SPACE_RESET;
         one_space_ff    <= nec_ir_pkg::ONE_SPACE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            nec_ir_pkg::CSR_DECODE_MARGIN: begin
               margin_ff <= csr_wdata[nec_ir_pkg::MARGIN_WIDTH-1:0];
            end
            nec_ir_pkg::CSR_LEADER_MARK_TICKS:  leader_mark_ff  <= csr_wdata;
            nec_ir_pkg::CSR_LEADER_SPACE_TICKS: leader_space_ff <= csr_wdata;
            nec_ir_pkg::CSR_REPEAT_SPACE_TICKS: repeat_space_ff <= csr_wdata;
            nec_ir_pkg::CSR_BIT_MARK_TICKS:     bit_mark_ff     <= csr_wdata;
            nec_ir_pkg::CSR_ZERO_SPACE_TICKS:   zero_space_ff   <= csr_wdata;
            nec_ir_pkg::CSR_ONE_SPACE_TICKS:    one_space_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         symbol_index_ff  <= '0;
         leader_good_ff   <= 1'b0;
         repeat_good_ff   <= 1'b0;
         bits_good_ff     <= 1'b1;
         payload_shift_ff <= '0;
         saved_address_ff <= '0;
         saved_command_ff <= '0;
      end else begin
         hold_valid_ff    <= hold_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         symbol_index_ff  <= symbol_index_in;
         leader_good_ff   <= leader_good_in;
         repeat_good_ff   <= repeat_good_in;
         bits_good_ff     <= bits_good_in;
         payload_shift_ff <= payload_shift_in;
         saved_address_ff <= saved_address_in;
         saved_command_ff <= saved_command_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hold_word_ff <= req_data;
      end
      rsp_word_ff <= rsp_word_in;
   end

endmodule

### sv/nec_ir_checker.sv
module nec_ir_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input nec_ir_pkg::rsp_word_type rsp_data
);

   logic [nec_ir_pkg::CODE_WIDTH-1:0] last_address_ff;
   logic [nec_ir_pkg::CODE_WIDTH-1:0] last_command_ff;
   logic                              rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   // Tracks the code of the last new-code word seen on the response side.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_address_ff <= '0;
         last_command_ff <= '0;
      end else if (rsp_take && rsp_data.frame_status == nec_ir_pkg::FRAME_NEW_CODE) begin
         last_address_ff <= rsp_data.code_address;
         last_command_ff <= rsp_data.code_command;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while response side is free");

   a_saved_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_status != nec_ir_pkg::FRAME_NEW_CODE |->
         rsp_data.code_address == last_address_ff &&
         rsp_data.code_command == last_command_ff)
      else $error("saved code changed without a new code");

   a_req_valid_known: assert property (@(posedge clock) disable iff (reset)
      req_stall && req_valid |=> req_valid || !$past(req_stall))
      else $error("request word withdrawn while stalled");

endmodule

bind nec_ir_frame_decoder_core nec_ir_checker u_nec_ir_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### verif/nec_ir_frame_decoder_core_tb.sv
`timescale 1ns / 100ps

module nec_ir_frame_decoder_core_tb;

   localparam int unsigned STALL_LIMIT      = 5000;
   localparam int unsigned SETTLE_CYCLES    = 4;
   localparam int unsigned MAX_REPORTS      = 10;
   localparam int          TICK_MAX         = 32767;
   localparam int unsigned PHASE_SYMBOLS    = 300;
   localparam logic [2:0]  CSR_UNUSED_INDEX = 3'd7;
   localparam int          NO_DAMAGE        = -1;
   localparam int          DAMAGE_LEADER    = 0;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   nec_ir_pkg::req_word_type            req_data;
   logic                                rsp_valid;
   logic                                rsp_stall;
   nec_ir_pkg::rsp_word_type            rsp_data;
   logic                                csr_write_enable;
   nec_ir_pkg::csr_index_type           csr_index;
   logic [nec_ir_pkg::CSR_WIDTH-1:0]    csr_wdata;

   // Local copy of the timing registers and the frame state.
   logic [nec_ir_pkg::TICK_WIDTH-1:0]  timing_reg [0:6];
   logic [nec_ir_pkg::INDEX_WIDTH-1:0] symbol_count;
   logic                               leader_ok;
   logic                               repeat_ok;
   logic                               bits_ok;
   logic [31:0]                        payload_bits;
   logic [nec_ir_pkg::CODE_WIDTH-1:0]  saved_address;
   logic [nec_ir_pkg::CODE_WIDTH-1:0]  saved_command;
   nec_ir_pkg::rsp_word_type           expected_frames [$];

   int mismatch_count;
   int symbols_sent;
   int idle_pct;
   int stall_pct;
   int quiet_cycles;

   nec_ir_frame_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Strict window; the sums are signed so a margin above the nominal value
   // opens the window all the way down to zero.
   function automatic bit fits(input logic [nec_ir_pkg::TICK_WIDTH-1:0] ticks,
                               input logic [nec_ir_pkg::TICK_WIDTH-1:0] nominal);
      int d;
      int n;
      int m;
      d = ticks;
      n = nominal;
      m = timing_reg[nec_ir_pkg::CSR_DECODE_MARGIN];
      return (d < n + m) && (d > n - m);
   endfunction

   function automatic void clear_frame_state();
      symbol_count = '0;
      leader_ok    = 1'b0;
      repeat_ok    = 1'b0;
      bits_ok      = 1'b1;
      payload_bits = '0;
   endfunction

   function automatic void reset_decoder_model();
      timing_reg[nec_ir_pkg::CSR_DECODE_MARGIN] =
         nec_ir_pkg::TICK_WIDTH'(nec_ir_pkg::MARGIN_RESET);
      timing_reg[nec_ir_pkg::CSR_LEADER_MARK_TICKS]  = nec_ir_pkg::LEADER_MARK_RESET;
      timing_reg[nec_ir_pkg::CSR_LEADER_SPACE_TICKS] = nec_ir_pkg::LEADER_SPACE_RESET;
      timing_reg[nec_ir_pkg::CSR_REPEAT_SPACE_TICKS] = nec_ir_pkg::REPEAT_SPACE_RESET;
      timing_reg[nec_ir_pkg::CSR_BIT_MARK_TICKS]     = nec_ir_pkg::BIT_MARK_RESET;
      timing_reg[nec_ir_pkg::CSR_ZERO_SPACE_TICKS]   = nec_ir_pkg::ZERO_SPACE_RESET;
      timing_reg[nec_ir_pkg::CSR_ONE_SPACE_TICKS]    = nec_ir_pkg::ONE_SPACE_RESET;
      clear_frame_state();
      saved_address = '0;
      saved_command = '0;
   endfunction

   function automatic void decode_symbol(input nec_ir_pkg::req_word_type w);
      logic [nec_ir_pkg::INDEX_WIDTH-1:0] count;
      logic                               bit_value;
      nec_ir_pkg::rsp_word_type           frame;
      if (symbol_count == 0) begin
         leader_ok = fits(w.mark_ticks, timing_reg[nec_ir_pkg::CSR_LEADER_MARK_TICKS]) &&
                     fits(w.space_ticks, timing_reg[nec_ir_pkg::CSR_LEADER_SPACE_TICKS]);
         repeat_ok = fits(w.mark_ticks, timing_reg[nec_ir_pkg::CSR_LEADER_MARK_TICKS]) &&
                     fits(w.space_ticks, timing_reg[nec_ir_pkg::CSR_REPEAT_SPACE_TICKS]);
      end else if (symbol_count <= nec_ir_pkg::LAST_BIT_INDEX) begin
         bit_value = 1'b0;
         if (!fits(w.mark_ticks, timing_reg[nec_ir_pkg::CSR_BIT_MARK_TICKS])) begin
            bits_ok = 1'b0;
         end else if (fits(w.space_ticks, timing_reg[nec_ir_pkg::CSR_ONE_SPACE_TICKS])) begin
            bit_value = 1'b1;
         end else if (!fits(w.space_ticks,
                            timing_reg[nec_ir_pkg::CSR_ZERO_SPACE_TICKS])) begin
            bits_ok = 1'b0;
         end
         payload_bits[int'(symbol_count) - 1] = bit_value;
      end
      count = (symbol_count < nec_ir_pkg::INDEX_MAX) ? symbol_count + 1'b1
                                                      : nec_ir_pkg::INDEX_MAX;
      if (!w.frame_end) begin
         symbol_count = count;
         return;
      end
      frame.code_address = saved_address;
      frame.code_command = saved_command;
      if (count == nec_ir_pkg::FRAME_SYMBOLS) begin
         if (leader_ok && bits_ok) begin
            saved_address      = payload_bits[15:0];
            saved_command      = payload_bits[31:16];
            frame.code_address = saved_address;
            frame.code_command = saved_command;
            frame.frame_status = nec_ir_pkg::FRAME_NEW_CODE;
         end else begin
            frame.frame_status = nec_ir_pkg::FRAME_TIMING_ERROR;
         end
      end else if (count == nec_ir_pkg::REPEAT_SYMBOLS) begin
         frame.frame_status = repeat_ok ? nec_ir_pkg::FRAME_REPEAT
                                        : nec_ir_pkg::FRAME_TIMING_ERROR;
      end else begin
         frame.frame_status = nec_ir_pkg::FRAME_UNKNOWN_LENGTH;
      end
      expected_frames.push_back(frame);
      clear_frame_state();
   endfunction

   function automatic void check_frame(input nec_ir_pkg::rsp_word_type got);
      nec_ir_pkg::rsp_word_type want;
      if (expected_frames.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected response word: status %0d address %h command %h",
                     got.frame_status, got.code_address, got.code_command);
         end
         return;
      end
      want = expected_frames.pop_front();
      if (got.frame_status !== want.frame_status ||
          got.code_address !== want.code_address ||
          got.code_command !== want.code_command) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display({"response mismatch: expected status %0d address %h command %h,",
                      " got status %0d address %h command %h"},
                     want.frame_status, want.code_address, want.code_command,
                     got.frame_status, got.code_address, got.code_command);
         end
      end
   endfunction

   // Both channels are sampled here, before the edge's updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            check_frame(rsp_data);
         end
         if (req_valid && !req_stall) begin
            decode_symbol(req_data);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_symbol(input logic [nec_ir_pkg::TICK_WIDTH-1:0] mark,
                              input logic [nec_ir_pkg::TICK_WIDTH-1:0] space,
                              input logic last);
      nec_ir_pkg::req_word_type w;
      w.mark_ticks  = mark;
      w.space_ticks = space;
      w.frame_end   = last;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      symbols_sent++;
   endtask

   // Waits until every frame result has come back and the pipeline is empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_timing(input nec_ir_pkg::csr_index_type idx,
                               input logic [nec_ir_pkg::CSR_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      case (idx)
         nec_ir_pkg::CSR_DECODE_MARGIN: begin
            timing_reg[idx] = nec_ir_pkg::TICK_WIDTH'(value[nec_ir_pkg::MARGIN_WIDTH-1:0]);
         end
         nec_ir_pkg::CSR_LEADER_MARK_TICKS, nec_ir_pkg::CSR_LEADER_SPACE_TICKS,
         nec_ir_pkg::CSR_REPEAT_SPACE_TICKS, nec_ir_pkg::CSR_BIT_MARK_TICKS,
         nec_ir_pkg::CSR_ZERO_SPACE_TICKS, nec_ir_pkg::CSR_ONE_SPACE_TICKS: begin
            timing_reg[idx] = value;
         end
         default: ;
      endcase
   endtask

   task automatic set_timing(input logic [nec_ir_pkg::CSR_WIDTH-1:0] margin,
                             input logic [nec_ir_pkg::CSR_WIDTH-1:0] leader_mark,
                             input logic [nec_ir_pkg::CSR_WIDTH-1:0] leader_space,
                             input logic [nec_ir_pkg::CSR_WIDTH-1:0] repeat_space,
                             input logic [nec_ir_pkg::CSR_WIDTH-1:0] bit_mark,
                             input logic [nec_ir_pkg::CSR_WIDTH-1:0] zero_space,
                             input logic [nec_ir_pkg::CSR_WIDTH-1:0] one_space);
      write_timing(nec_ir_pkg::CSR_DECODE_MARGIN, margin);
      write_timing(nec_ir_pkg::CSR_LEADER_MARK_TICKS, leader_mark);
      write_timing(nec_ir_pkg::CSR_LEADER_SPACE_TICKS, leader_space);
      write_timing(nec_ir_pkg::CSR_REPEAT_SPACE_TICKS, repeat_space);
      write_timing(nec_ir_pkg::CSR_BIT_MARK_TICKS, bit_mark);
      write_timing(nec_ir_pkg::CSR_ZERO_SPACE_TICKS, zero_space);
      write_timing(nec_ir_pkg::CSR_ONE_SPACE_TICKS, one_space);
   endtask

   // A duration near a nominal value, mostly inside its window and now and then
   // right on or just inside one of its edges.
   function automatic logic [nec_ir_pkg::TICK_WIDTH-1:0] near(
         input logic [nec_ir_pkg::TICK_WIDTH-1:0] nominal);
      int m;
      int ticks;
      m = timing_reg[nec_ir_pkg::CSR_DECODE_MARGIN];
      if (m == 0) begin
         ticks = nominal;
      end else if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0:       ticks = nominal + m;
            1:       ticks = nominal + m - 1;
            2:       ticks = nominal - m + 1;
            default: ticks = nominal - m;
         endcase
      end else begin
         ticks = nominal + int'($urandom_range(2 * m - 2)) - (m - 1);
      end
      if (ticks < 0) ticks = 0;
      if (ticks > TICK_MAX) ticks = TICK_MAX;
      return ticks[nec_ir_pkg::TICK_WIDTH-1:0];
   endfunction

   function automatic logic [nec_ir_pkg::TICK_WIDTH-1:0] noise();
      return nec_ir_pkg::TICK_WIDTH'($urandom_range(TICK_MAX));
   endfunction

   function automatic logic [nec_ir_pkg::CSR_WIDTH-1:0] pick_nominal();
      case ($urandom_range(7))
         0:       return nec_ir_pkg::CSR_WIDTH'(512);
         1:       return nec_ir_pkg::CSR_WIDTH'(TICK_MAX);
         default: return nec_ir_pkg::CSR_WIDTH'($urandom_range(512, TICK_MAX));
      endcase
   endfunction

   // A full frame: leader, 32 payload bits LSB first, and the trailing mark.
   task automatic send_code(input logic [15:0] address, input logic [15:0] command,
                            input int damaged);
      logic [31:0]                       bits;
      logic [nec_ir_pkg::TICK_WIDTH-1:0] space;
      bits = {command, address};
      if (damaged == DAMAGE_LEADER) begin
         send_symbol(noise(), noise(), 1'b0);
      end else begin
         send_symbol(near(timing_reg[nec_ir_pkg::CSR_LEADER_MARK_TICKS]),
                     near(timing_reg[nec_ir_pkg::CSR_LEADER_SPACE_TICKS]), 1'b0);
      end
      for (int i = 1; i <= 32; i++) begin
         space = bits[i-1] ? near(timing_reg[nec_ir_pkg::CSR_ONE_SPACE_TICKS])
                           : near(timing_reg[nec_ir_pkg::CSR_ZERO_SPACE_TICKS]);
         if (i == damaged) begin
            space = noise();
         end
         send_symbol(near(timing_reg[nec_ir_pkg::CSR_BIT_MARK_TICKS]), space, 1'b0);
      end
      send_symbol(near(timing_reg[nec_ir_pkg::CSR_BIT_MARK_TICKS]), noise(), 1'b1);
   endtask

   task automatic send_repeat(input bit damaged);
      if (damaged) begin
         send_symbol(noise(), noise(), 1'b0);
      end else begin
         send_symbol(near(timing_reg[nec_ir_pkg::CSR_LEADER_MARK_TICKS]),
                     near(timing_reg[nec_ir_pkg::CSR_REPEAT_SPACE_TICKS]), 1'b0);
      end
      send_symbol(near(timing_reg[nec_ir_pkg::CSR_BIT_MARK_TICKS]), noise(), 1'b1);
   endtask

   task automatic send_run(input int length);
      logic [nec_ir_pkg::TICK_WIDTH-1:0] mark;
      logic [nec_ir_pkg::TICK_WIDTH-1:0] space;
      for (int i = 1; i <= length; i++) begin
         mark  = $urandom_range(1) ? near(timing_reg[nec_ir_pkg::CSR_BIT_MARK_TICKS])
                                   : noise();
         space = $urandom_range(1) ? near(timing_reg[nec_ir_pkg::CSR_ZERO_SPACE_TICKS])
                                   : noise();
         send_symbol(mark, space, i == length);
      end
   endtask

   task automatic send_random_frame();
      int sel;
      sel = $urandom_range(99);
      if (sel < 55) begin
         send_code(16'($urandom), 16'($urandom),
                   ($urandom_range(4) == 0) ? int'($urandom_range(32)) : NO_DAMAGE);
      end else if (sel < 75) begin
         send_repeat($urandom_range(5) == 0);
      end else if (sel < 88) begin
         send_run($urandom_range(1, 70));
      end else begin
         send_symbol(noise(), noise(), $urandom_range(7) == 0);
      end
   endtask

   task automatic test_frame_kinds();
      send_code(16'hFFFF, 16'h0000, NO_DAMAGE);
      send_code(16'h0000, 16'hFFFF, NO_DAMAGE);
      send_repeat(1'b0);
      send_repeat(1'b1);
      send_code(16'hA5C3, 16'h5A3C, 17);
      send_code(16'h1234, 16'h8765, DAMAGE_LEADER);
      send_repeat(1'b0);
      settle();
   endtask

   task automatic test_frame_lengths();
      send_run(1);
      send_run(3);
      send_run(33);
      send_run(35);
      // Long enough for the symbol counter to saturate.
      send_run(70);
      settle();
   endtask

   task automatic test_window_edges();
      send_symbol(nec_ir_pkg::LEADER_MARK_RESET + nec_ir_pkg::MARGIN_RESET - 1'b1,
                  nec_ir_pkg::REPEAT_SPACE_RESET, 1'b0);
      send_symbol(nec_ir_pkg::BIT_MARK_RESET, 15'd0, 1'b1);
      send_symbol(nec_ir_pkg::LEADER_MARK_RESET + nec_ir_pkg::MARGIN_RESET,
                  nec_ir_pkg::REPEAT_SPACE_RESET, 1'b0);
      send_symbol(nec_ir_pkg::BIT_MARK_RESET, 15'd0, 1'b1);
      send_symbol(nec_ir_pkg::LEADER_MARK_RESET - nec_ir_pkg::MARGIN_RESET + 1'b1,
                  nec_ir_pkg::REPEAT_SPACE_RESET - nec_ir_pkg::MARGIN_RESET + 1'b1, 1'b0);
      send_symbol(nec_ir_pkg::BIT_MARK_RESET, 15'd0, 1'b1);
      send_symbol(nec_ir_pkg::LEADER_MARK_RESET,
                  nec_ir_pkg::REPEAT_SPACE_RESET - nec_ir_pkg::MARGIN_RESET, 1'b0);
      send_symbol(nec_ir_pkg::BIT_MARK_RESET, 15'd0, 1'b1);
      send_symbol(15'h7FFF, 15'd0, 1'b1);
      send_symbol(15'd0, 15'h7FFF, 1'b1);
      settle();
   endtask

   task automatic test_margin_extremes();
      // With no margin the strict window is empty and nothing decodes.
      write_timing(nec_ir_pkg::CSR_DECODE_MARGIN, 15'd0);
      send_code(16'h00FF, 16'hFF00, NO_DAMAGE);
      send_repeat(1'b0);
      settle();
      // The margin register keeps its low nine bits; nominal values below
      // the margin leave the windows open down to zero.
      set_timing(15'h7FFF, 15'd100, 15'd0, 15'h7FFF, 15'd300, 15'd0, 15'h7FFF);
      send_code(16'h8001, 16'h7FFE, NO_DAMAGE);
      send_repeat(1'b0);
      repeat (12) send_random_frame();
      settle();
      write_timing(nec_ir_pkg::csr_index_type'(CSR_UNUSED_INDEX), 15'h0123);
      send_code(16'hC3A5, 16'h3C5A, NO_DAMAGE);
      send_repeat(1'b0);
      settle();
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input bit default_timing);
      int target;
      if (default_timing) begin
         set_timing(nec_ir_pkg::TICK_WIDTH'(nec_ir_pkg::MARGIN_RESET),
                    nec_ir_pkg::LEADER_MARK_RESET, nec_ir_pkg::LEADER_SPACE_RESET,
                    nec_ir_pkg::REPEAT_SPACE_RESET, nec_ir_pkg::BIT_MARK_RESET,
                    nec_ir_pkg::ZERO_SPACE_RESET, nec_ir_pkg::ONE_SPACE_RESET);
      end else begin
         set_timing(($urandom_range(3) == 0) ?
                       nec_ir_pkg::CSR_WIDTH'($urandom_range(511)) :
                       nec_ir_pkg::CSR_WIDTH'($urandom_range(40, 300)),
                    pick_nominal(), pick_nominal(), pick_nominal(),
                    pick_nominal(), pick_nominal(), pick_nominal());
      end
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      target    = symbols_sent + PHASE_SYMBOLS;
      while (symbols_sent < target) send_random_frame();
      settle();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = nec_ir_pkg::CSR_DECODE_MARGIN;
      csr_wdata        = '0;
      mismatch_count   = 0;
      symbols_sent     = 0;
      idle_pct         = 0;
      stall_pct        = 0;
      quiet_cycles     = 0;
      reset_decoder_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_frame_kinds();
      test_frame_lengths();
      test_window_edges();
      test_margin_extremes();
      test_random_traffic(0, 0, 1'b1);
      test_random_traffic(50, 0, 1'b0);
      test_random_traffic(0, 50, 1'b0);
      test_random_traffic(15, 15, 1'b0);

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### nec_ir_frame_decoder_core.f
sv/nec_ir_pkg.sv
sv/nec_ir_frame_decoder_core.sv
sv/nec_ir_checker.sv
verif/nec_ir_frame_decoder_core_tb.sv
